/* rtl/rlid_pkg.sv */
// ----------------------------------------------------------------------------
// rlid_pkg
// Types and constants shared by the run-length image decoder: the transfer
// payloads of both channels, the parse phase codes and the opcode fields.
// ----------------------------------------------------------------------------
package rlid_pkg;

	localparam int unsigned CHAN_COUNT_W = 4;
	localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RESET = 4'd3;

	localparam logic [7:0]  FORM_MASK      = 8'hC0;
	localparam logic [7:0]  FORM_LONG      = 8'h40;
	localparam logic [15:0] CHAN_LAST_CODE = 16'd255;

	typedef enum logic [5:0] {
		OP_SKIP_LINES  = 6'd1,
		OP_SET_CHANNEL = 6'd2,
		OP_SKIP_PIXELS = 6'd3,
		OP_PIXEL_DATA  = 6'd5,
		OP_RUN         = 6'd6,
		OP_END         = 6'd7
	} rlid_op_t;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_RUN     = 2'd1,
		KIND_END     = 2'd2,
		KIND_ILLEGAL = 2'd3
	} rlid_kind_t;

	typedef enum logic [3:0] {
		PH_OPCODE    = 4'd0,
		PH_PAD       = 4'd1,
		PH_OP_LOW    = 4'd2,
		PH_OP_HIGH   = 4'd3,
		PH_SHORT_OP  = 4'd4,
		PH_PIX_BYTES = 4'd5,
		PH_PIX_PAD   = 4'd6,
		PH_RUN_VALUE = 4'd7,
		PH_RUN_PAD   = 4'd8
	} rlid_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} rlid_in_t;

	typedef struct packed {
		rlid_kind_t  kind;
		logic [15:0] line;
		logic [15:0] pixel;
		logic [7:0]  channel;
		logic [16:0] run_length;
		logic [7:0]  value;
	} rlid_out_t;

	function automatic logic opcode_legal(input logic [7:0] op);
		logic code_ok;
		code_ok = op[5:0] inside {OP_SKIP_LINES, OP_SET_CHANNEL, OP_SKIP_PIXELS,
			OP_PIXEL_DATA, OP_RUN, OP_END};
		return ((op & FORM_MASK) == 8'h00 || (op & FORM_MASK) == FORM_LONG) && code_ok;
	endfunction

endpackage

/* rtl/run_length_image_decoder.sv */
// ----------------------------------------------------------------------------
// run_length_image_decoder
// Byte-serial parser for the coded image part of a run-length picture.
// ----------------------------------------------------------------------------
// Takes one stream byte per transfer and turns the opcode stream into pixel
// writes, run fills, an end-of-image mark and an illegal-opcode mark, each
// carrying the line, pixel and channel it applies to. Throughput is one byte
// per clock while the output does not stall: a byte lands in the input
// register, the parser decodes it combinationally against the current parse
// state and the result register takes the outcome when the byte advances,
// so each result is offered straight from the result register. Only the
// output stall holds the pipe back; the input side keeps taking bytes as long
// as the input register is empty or the result register is free or being
// drained in the same cycle. first_byte restarts position and parse state at an
// image boundary; after an end-of-image or illegal opcode every byte is
// dropped until the next first_byte. channel_count is written through
// cfg_we/cfg_wdata and should only change while the decoder is idle.
// ----------------------------------------------------------------------------
module run_length_image_decoder
	import rlid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  rlid_in_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output rlid_out_t               out_data,
	input  logic                    cfg_we,
	input  logic [CHAN_COUNT_W-1:0] cfg_wdata
);

	// Configuration
	logic [CHAN_COUNT_W-1:0] chan_count_q;

	// Input register
	logic     valid_s1;
	rlid_in_t data_s1;

	// Parse state
	rlid_phase_t phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [7:0]  op_low_q, op_low_d;
	logic [15:0] line_q, line_d;
	logic [15:0] pixel_q, pixel_d;
	logic [7:0]  chan_q, chan_d;
	logic [16:0] remain_q, remain_d;
	logic        odd_q, odd_d;
	logic        stopped_q, stopped_d;

	// State as seen by the current byte, after an optional restart
	rlid_phase_t cur_phase;
	logic [7:0]  cur_opcode;
	logic [7:0]  cur_op_low;
	logic [15:0] cur_line;
	logic [15:0] cur_pixel;
	logic [7:0]  cur_chan;
	logic [16:0] cur_remain;
	logic        cur_odd;
	logic        cur_stopped;

	logic        apply;
	logic [15:0] operand;
	logic [16:0] remain_dec;
	logic [7:0]  b;

	// Result
	logic      res_valid;
	rlid_out_t res;
	logic      out_valid_q;
	rlid_out_t out_data_q;

	logic adv;
	logic in_xfer;

	// Advance the byte in the input register when the result register can take
	// whatever it produces.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;
	assign b        = data_s1.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= CHAN_COUNT_RESET;
		end else if (cfg_we) begin
			chan_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= in_data;
		end
	end

	// Restart on first_byte before parsing the byte itself.
	always_comb begin
		if (data_s1.first_byte) begin
			cur_phase   = PH_OPCODE;
			cur_opcode  = '0;
			cur_op_low  = '0;
			cur_line    = '0;
			cur_pixel   = '0;
			cur_chan    = '0;
			cur_remain  = '0;
			cur_odd     = 1'b0;
			cur_stopped = 1'b0;
		end else begin
			cur_phase   = phase_q;
			cur_opcode  = opcode_q;
			cur_op_low  = op_low_q;
			cur_line    = line_q;
			cur_pixel   = pixel_q;
			cur_chan    = chan_q;
			cur_remain  = remain_q;
			cur_odd     = odd_q;
			cur_stopped = stopped_q;
		end
	end

	assign remain_dec = cur_remain - 17'd1;

	// Next parse state
	always_comb begin
		phase_d   = cur_phase;
		opcode_d  = cur_opcode;
		op_low_d  = cur_op_low;
		line_d    = cur_line;
		pixel_d   = cur_pixel;
		chan_d    = cur_chan;
		remain_d  = cur_remain;
		odd_d     = cur_odd;
		stopped_d = cur_stopped;
		apply     = 1'b0;
		operand   = {8'h00, b};

		if (!cur_stopped) begin
			case (cur_phase)
				PH_OPCODE: begin
					if (!opcode_legal(b)) begin
						stopped_d = 1'b1;
					end else begin
						opcode_d = b;
						if ((b & FORM_MASK) == FORM_LONG || b[5:0] == OP_END) begin
							phase_d = PH_PAD;
						end else begin
							phase_d = PH_SHORT_OP;
						end
					end
				end
				PH_PAD: begin
					if (cur_opcode[5:0] == OP_END) begin
						stopped_d = 1'b1;
						phase_d   = PH_OPCODE;
					end else begin
						phase_d = PH_OP_LOW;
					end
				end
				PH_OP_LOW: begin
					op_low_d = b;
					phase_d  = PH_OP_HIGH;
				end
				PH_OP_HIGH: begin
					apply   = 1'b1;
					operand = {b, cur_op_low};
				end
				PH_SHORT_OP: begin
					apply = 1'b1;
				end
				PH_PIX_BYTES: begin
					pixel_d  = cur_pixel + 16'd1;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						phase_d = cur_odd ? PH_PIX_PAD : PH_OPCODE;
					end
				end
				PH_RUN_VALUE: begin
					pixel_d  = cur_pixel + cur_remain[15:0];
					remain_d = '0;
					phase_d  = PH_RUN_PAD;
				end
				default: begin
					phase_d = PH_OPCODE;
				end
			endcase

			// Act on a complete operand.
			if (apply) begin
				phase_d = PH_OPCODE;
				case (cur_opcode[5:0])
					OP_SKIP_LINES: begin
						line_d  = cur_line + operand;
						pixel_d = '0;
					end
					OP_SET_CHANNEL: begin
						if (operand == CHAN_LAST_CODE) begin
							chan_d = {4'h0, chan_count_q} - 8'd1;
						end else begin
							chan_d = operand[7:0];
						end
						pixel_d = '0;
					end
					OP_SKIP_PIXELS: begin
						pixel_d = cur_pixel + operand;
					end
					OP_PIXEL_DATA: begin
						remain_d = {1'b0, operand} + 17'd1;
						odd_d    = ~operand[0];
						phase_d  = PH_PIX_BYTES;
					end
					OP_RUN: begin
						remain_d = {1'b0, operand} + 17'd1;
						phase_d  = PH_RUN_VALUE;
					end
					default: begin
						phase_d = PH_OPCODE;
					end
				endcase
			end
		end
	end

	// Result of the current byte
	always_comb begin
		res_valid      = 1'b0;
		res.kind       = KIND_PIXEL;
		res.line       = cur_line;
		res.pixel      = cur_pixel;
		res.channel    = cur_chan;
		res.run_length = 17'd1;
		res.value      = b;
		if (!cur_stopped) begin
			case (cur_phase)
				PH_OPCODE: begin
					if (!opcode_legal(b)) begin
						res_valid = 1'b1;
						res.kind  = KIND_ILLEGAL;
					end
				end
				PH_PAD: begin
					if (cur_opcode[5:0] == OP_END) begin
						res_valid = 1'b1;
						res.kind  = KIND_END;
						res.value = '0;
					end
				end
				PH_PIX_BYTES: begin
					res_valid = 1'b1;
				end
				PH_RUN_VALUE: begin
					res_valid      = 1'b1;
					res.kind       = KIND_RUN;
					res.run_length = cur_remain;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// Commit parse state when the byte advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OPCODE;
			opcode_q  <= '0;
			op_low_q  <= '0;
			line_q    <= '0;
			pixel_q   <= '0;
			chan_q    <= '0;
			remain_q  <= '0;
			odd_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			op_low_q  <= op_low_d;
			line_q    <= line_d;
			pixel_q   <= pixel_d;
			chan_q    <= chan_d;
			remain_q  <= remain_d;
			odd_q     <= odd_d;
			stopped_q <= stopped_d;
		end
	end

	// Result register: load on advance, drop once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A stopped parser drops bytes without producing results.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && stopped_q && !data_s1.first_byte |=> !out_valid_q)
		else $error("result produced while stopped");

	// End of image and illegal opcode both stop the parser.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_valid && (res.kind == KIND_END || res.kind == KIND_ILLEGAL)
		|=> stopped_q)
		else $error("parser not stopped after terminating result");

	// Literal and run phases always have a nonzero count pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIX_BYTES || phase_q == PH_RUN_VALUE) |-> remain_q != '0)
		else $error("pixel count empty in data phase");

endmodule

/* tb/sv/rlid_stream_checker.sv */
// ----------------------------------------------------------------------------
// rlid_stream_checker
// Watches both channels of the run-length image decoder, keeps its own
// decoder state, predicts every pixel write, run fill, end mark and illegal
// mark, and compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module rlid_stream_checker
	import rlid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  rlid_in_t                in_data,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  rlid_out_t               out_data,
	input  logic                    cfg_we,
	input  logic [CHAN_COUNT_W-1:0] cfg_wdata,
	output int unsigned             fail_count,
	output int unsigned             outstanding,
	output int unsigned             results_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_MAX = 10;

	logic [CHAN_COUNT_W-1:0] chan_count;
	rlid_phase_t             phase;
	logic [7:0]              held_op;
	logic [7:0]              op_low;
	logic [15:0]             cur_line;
	logic [15:0]             cur_pix;
	logic [7:0]              cur_chan;
	logic [16:0]             remaining;
	logic                    odd_len;
	logic                    halted;

	rlid_out_t   decoded_q[$];
	int unsigned n_fail;
	int unsigned n_checked;

	task automatic restart_image();
		phase     = PH_OPCODE;
		held_op   = '0;
		op_low    = '0;
		cur_line  = '0;
		cur_pix   = '0;
		cur_chan  = '0;
		remaining = '0;
		odd_len   = 1'b0;
		halted    = 1'b0;
	endtask

	function automatic logic opcode_known(input logic [7:0] op);
		logic code_ok;
		case (op[5:0])
			OP_SKIP_LINES, OP_SET_CHANNEL, OP_SKIP_PIXELS,
			OP_PIXEL_DATA, OP_RUN, OP_END: code_ok = 1'b1;
			default: code_ok = 1'b0;
		endcase
		return code_ok && (op[7:6] == FORM_LONG[7:6] || op[7:6] == 2'b00);
	endfunction

	function automatic rlid_out_t make_result(input rlid_kind_t k, input logic [16:0] len,
			input logic [7:0] val);
		rlid_out_t r;
		r.kind       = k;
		r.line       = cur_line;
		r.pixel      = cur_pix;
		r.channel    = cur_chan;
		r.run_length = len;
		r.value      = val;
		return r;
	endfunction

	// Apply a complete operand to the held opcode.
	task automatic take_operand(input logic [15:0] v);
		phase = PH_OPCODE;
		case (held_op[5:0])
			OP_SKIP_LINES: begin
				cur_line = cur_line + v;
				cur_pix  = '0;
			end
			OP_SET_CHANNEL: begin
				// count minus one wraps to 255 when the count is zero
				cur_chan = (v == CHAN_LAST_CODE) ? ({4'h0, chan_count} - 8'd1) : v[7:0];
				cur_pix  = '0;
			end
			OP_SKIP_PIXELS: cur_pix = cur_pix + v;
			OP_PIXEL_DATA: begin
				remaining = {1'b0, v} + 17'd1;
				odd_len   = remaining[0];
				phase     = PH_PIX_BYTES;
			end
			OP_RUN: begin
				remaining = {1'b0, v} + 17'd1;
				phase     = PH_RUN_VALUE;
			end
			default: ;
		endcase
	endtask

	task automatic decode_byte(input rlid_in_t b, output bit has_res, output rlid_out_t res);
		logic [7:0] d;
		d       = b.data_byte;
		has_res = 1'b0;
		res     = '0;
		if (b.first_byte)
			restart_image();
		if (halted)
			return;
		case (phase)
			PH_OPCODE: begin
				if (!opcode_known(d)) begin
					res     = make_result(KIND_ILLEGAL, 17'd1, d);
					has_res = 1'b1;
					halted  = 1'b1;
				end else begin
					held_op = d;
					if ((d & FORM_MASK) == FORM_LONG || d[5:0] == OP_END)
						phase = PH_PAD;
					else
						phase = PH_SHORT_OP;
				end
			end
			PH_PAD: begin
				if (held_op[5:0] == OP_END) begin
					res     = make_result(KIND_END, 17'd1, 8'h00);
					has_res = 1'b1;
					halted  = 1'b1;
					phase   = PH_OPCODE;
				end else begin
					phase = PH_OP_LOW;
				end
			end
			PH_OP_LOW: begin
				op_low = d;
				phase  = PH_OP_HIGH;
			end
			PH_OP_HIGH:  take_operand({d, op_low});
			PH_SHORT_OP: take_operand({8'h00, d});
			PH_PIX_BYTES: begin
				res       = make_result(KIND_PIXEL, 17'd1, d);
				has_res   = 1'b1;
				cur_pix   = cur_pix + 16'd1;
				remaining = remaining - 17'd1;
				if (remaining == 17'd0)
					phase = odd_len ? PH_PIX_PAD : PH_OPCODE;
			end
			PH_RUN_VALUE: begin
				res       = make_result(KIND_RUN, remaining, d);
				has_res   = 1'b1;
				cur_pix   = cur_pix + remaining[15:0];
				remaining = '0;
				phase     = PH_RUN_PAD;
			end
			default: phase = PH_OPCODE;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rlid_out_t want;
		bit        got_one;
		if (!arst_n) begin
			chan_count = CHAN_COUNT_RESET;
			restart_image();
			decoded_q.delete();
			n_fail          = 0;
			n_checked       = 0;
			fail_count      <= 0;
			outstanding     <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					n_fail++;
					if (n_fail <= REPORT_MAX)
						$display("%0t: unexpected result kind=%0d line=%0d pixel=%0d",
							$time, out_data.kind, out_data.line, out_data.pixel);
				end else begin
					want = decoded_q.pop_front();
					n_checked++;
					if (out_data.kind !== want.kind || out_data.line !== want.line ||
							out_data.pixel !== want.pixel || out_data.channel !== want.channel ||
							out_data.run_length !== want.run_length ||
							out_data.value !== want.value) begin
						n_fail++;
						if (n_fail <= REPORT_MAX) begin
							$display("%0t: mismatch", $time);
							$display("  expected kind=%0d line=%0d pix=%0d ch=%0d len=%0d val=%0h",
								want.kind, want.line, want.pixel, want.channel,
								want.run_length, want.value);
							$display("  actual   kind=%0d line=%0d pix=%0d ch=%0d len=%0d val=%0h",
								out_data.kind, out_data.line, out_data.pixel,
								out_data.channel, out_data.run_length, out_data.value);
						end
					end
				end
			end
			if (cfg_we)
				chan_count = cfg_wdata;
			if (in_valid && !in_stall) begin
				decode_byte(in_data, got_one, want);
				if (got_one)
					decoded_q.push_back(want);
			end
			fail_count      <= n_fail;
			outstanding     <= decoded_q.size();
			results_checked <= n_checked;
		end
	end

endmodule

/* tb/sv/run_length_image_decoder_tb.sv */
// ----------------------------------------------------------------------------
// run_length_image_decoder_tb
// Stream-level test of the run-length image decoder.
// ----------------------------------------------------------------------------
// Feeds a short directed stream that hits the operand extremes, the wide
// channel operand, the last-channel code, the longest run and both illegal
// and end marks, then a long random stream of mostly well-formed images with
// noise, truncated images and illegal opcodes mixed in. channel_count is
// swept through several values, the values 0, 1, 8 and 15 among them, with
// the decoder drained before each write. Both channels idle and stall at
// random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module run_length_image_decoder_tb
	import rlid_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned NUM_PHASES  = 7;
	// margin for bytes that leave no result
	localparam int unsigned SETTLE      = 6;
	localparam int unsigned DRAIN_LIMIT = 20000;
	localparam int unsigned TIMEOUT_NS  = 8_000_000;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	rlid_in_t                in_data;
	logic                    out_valid;
	logic                    out_stall;
	rlid_out_t               out_data;
	logic                    cfg_we;
	logic [CHAN_COUNT_W-1:0] cfg_wdata;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned results_checked;

	// stimulus bookkeeping
	int unsigned             items;
	int unsigned             images;
	int unsigned             calm_left;
	bit                      new_image;
	logic [CHAN_COUNT_W-1:0] cfg_plan [NUM_PHASES];

	run_length_image_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rlid_stream_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length shared by both sides: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Input side gap; open a calm stretch with no idling every so often.
	function automatic int unsigned in_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm_left = $urandom_range(20, 80);
			return 0;
		end
		return pick_gap();
	endfunction

	// Any byte value.
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one byte and hold it until the transfer happens. The first_byte
	// flag comes from new_image, which is consumed here. Keep valid high
	// across back-to-back bytes; drop it only to insert a gap.
	task automatic send(input logic [7:0] b, input bit counted);
		int unsigned g;
		g = in_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_data   <= '{data_byte: b, first_byte: new_image};
		new_image = 1'b0;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (counted)
			items++;
	endtask

	// Bytes sent while the decoder is stopped; they are dropped by design.
	task automatic send_ignored(input int unsigned n);
		repeat (n) send(rand_byte(), 1'b0);
	endtask

	// One complete command: opcode, operand in short or long form, and the
	// literal bytes, run value or pad that follow it.
	task automatic send_op(input rlid_op_t code, input bit lng, input logic [15:0] v,
			input logic [7:0] fill);
		int unsigned k;
		int unsigned n;
		send({1'b0, lng, code}, 1'b1);
		if (code == OP_END) begin
			send(rand_byte(), 1'b1);
			return;
		end
		if (lng) begin
			send(rand_byte(), 1'b1);
			send(v[7:0], 1'b1);
			send(v[15:8], 1'b1);
		end else begin
			send(v[7:0], 1'b1);
		end
		if (code == OP_PIXEL_DATA) begin
			n = v + 1;
			for (k = 0; k < n; k++)
				send(rand_byte(), 1'b1);
			if (n[0])
				send(rand_byte(), 1'b1);
		end else if (code == OP_RUN) begin
			send(fill, 1'b1);
			send(rand_byte(), 1'b1);
		end
	endtask

	// Opcode byte with a bad form field or an unused code.
	function automatic logic [7:0] illegal_opcode();
		logic [5:0] c;
		if ($urandom_range(0, 1) == 1)
			return {1'b1, 7'($urandom)};
		case ($urandom_range(0, 2))
			0:       c = 6'd0;
			1:       c = 6'd4;
			default: c = 6'($urandom_range(8, 63));
		endcase
		return {1'b0, 1'($urandom), c};
	endfunction

	// One random image. Most are well formed; some end on an illegal opcode,
	// some are cut short and restarted by the next first byte, and a few are
	// preceded by noise with a random first_byte flag.
	task automatic send_image();
		int unsigned ncmd;
		int unsigned i;
		int unsigned r;
		int unsigned n;
		rlid_op_t    code;
		bit          lng;
		bit          done;
		logic [15:0] v;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				new_image = 1'($urandom);
				send(rand_byte(), 1'b1);
			end
		end
		images++;
		new_image = 1'b1;
		ncmd = $urandom_range(1, 16);
		done = 1'b0;
		for (i = 0; i < ncmd && !done; i++) begin
			r   = $urandom_range(0, 99);
			lng = ($urandom_range(0, 2) == 0);
			if (r < 85) begin
				if (r < 10) begin
					code = OP_SKIP_LINES;
					v    = lng ? 16'($urandom) : 16'($urandom_range(0, 255));
				end else if (r < 22) begin
					code = OP_SET_CHANNEL;
					n    = $urandom_range(0, 9);
					if (n < 3)
						v = CHAN_LAST_CODE;
					else if (n == 3 && lng)
						v = {8'($urandom_range(1, 255)), 8'hFF};
					else
						v = lng ? 16'($urandom) : 16'($urandom_range(0, 255));
				end else if (r < 32) begin
					code = OP_SKIP_PIXELS;
					v    = lng ? 16'($urandom) : 16'($urandom_range(0, 255));
				end else if (r < 60) begin
					// keep literal blocks short, with a rare long one
					code = OP_PIXEL_DATA;
					if (lng)
						v = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 300))
							: 16'($urandom_range(0, 15));
					else
						v = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(0, 255))
							: 16'($urandom_range(0, 7));
				end else begin
					code = OP_RUN;
					if (lng)
						v = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom);
					else
						v = 16'($urandom_range(0, 255));
				end
				send_op(code, lng, v, rand_byte());
			end else if (r < 90) begin
				send(illegal_opcode(), 1'b1);
				send_ignored($urandom_range(0, 3));
				done = 1'b1;
			end else if (r < 94) begin
				// cut the image off mid-operand or mid-literal block
				if ($urandom_range(0, 1) == 1) begin
					send({2'b01, OP_SKIP_PIXELS}, 1'b1);
					repeat ($urandom_range(0, 2)) send(rand_byte(), 1'b1);
				end else begin
					send({2'b00, OP_PIXEL_DATA}, 1'b1);
					send(8'd7, 1'b1);
					repeat ($urandom_range(0, 7)) send(rand_byte(), 1'b1);
				end
				done = 1'b1;
			end else begin
				send_op(OP_END, lng, 16'h0000, 8'h00);
				send_ignored($urandom_range(0, 2));
				done = 1'b1;
			end
		end
		if (!done && $urandom_range(0, 9) < 8) begin
			send_op(OP_END, ($urandom_range(0, 1) == 1), 16'h0000, 8'h00);
			if ($urandom_range(0, 3) == 0)
				send_ignored($urandom_range(1, 3));
		end
	endtask

	// Hold the sender until every predicted result has come out, then let
	// the pipe settle. Bounded so a hang still reaches the verdict.
	task automatic drain();
		int unsigned w;
		in_valid <= 1'b0;
		w = 0;
		do begin
			@(posedge clk);
			w++;
		end while (outstanding != 0 && w < DRAIN_LIMIT);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_channel_count(input logic [CHAN_COUNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Output side: alternate stall bursts and free stretches, with an
	// occasional long free stretch.
	initial begin : out_side
		int unsigned st;
		int unsigned fr;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			st = pick_gap();
			if (st > 0) begin
				out_stall <= 1'b1;
				repeat (st) @(posedge clk);
			end
			out_stall <= 1'b0;
			fr = ($urandom_range(0, 24) == 0) ? $urandom_range(50, 200) : 1 + pick_gap();
			repeat (fr) @(posedge clk);
		end
	end

	// Main stimulus.
	initial begin : stimulus
		int unsigned ph;
		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		items     = 0;
		images    = 0;
		calm_left = 0;
		new_image = 1'b0;
		cfg_plan  = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd3};
		cfg_plan[5] = CHAN_COUNT_W'($urandom_range(1, 8));
		cfg_plan[6] = CHAN_COUNT_W'($urandom_range(0, 15));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_channel_count(cfg_plan[0]);

		// Directed image: last-channel code, skip to the last line, single
		// literal with its pad, longest run with pixel wrap, wide channel
		// operand, long-form end.
		images++;
		new_image = 1'b1;
		send_op(OP_SET_CHANNEL, 1'b0, CHAN_LAST_CODE, 8'h00);
		send_op(OP_SKIP_LINES, 1'b1, 16'hFFFF, 8'h00);
		send_op(OP_SKIP_PIXELS, 1'b0, 16'h00FF, 8'h00);
		send_op(OP_PIXEL_DATA, 1'b0, 16'h0000, 8'h00);
		send_op(OP_RUN, 1'b1, 16'hFFFF, 8'hFF);
		send_op(OP_SET_CHANNEL, 1'b1, 16'h01FF, 8'h00);
		send_op(OP_END, 1'b1, 16'h0000, 8'h00);
		// illegal opcode as the first byte of an image, then a dropped byte
		images++;
		new_image = 1'b1;
		send({2'b11, OP_PIXEL_DATA}, 1'b1);
		send_ignored(1);

		// Random images, one channel_count setting per phase. Drain before
		// each write so the register only changes while idle.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				write_channel_count(cfg_plan[ph]);
			end
			while (items < ((ph + 1) * ITEM_TARGET) / NUM_PHASES)
				send_image();
		end

		drain();

		$display("Run covered %0d stream bytes in %0d images, %0d results checked",
			items, images, results_checked);
		$display("channel_count settings: 3 1 8 0 15 %0d %0d", cfg_plan[5], cfg_plan[6]);
		if (outstanding != 0)
			$display("%0d predicted results never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop in case the decoder hangs.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/rlid_pkg.sv
rtl/run_length_image_decoder.sv
tb/sv/rlid_stream_checker.sv
tb/sv/run_length_image_decoder_tb.sv
